// ----- rtl/pcmp_pkg.sv -----
// pcmp_pkg: shared constants, command codes and register map of the pcm playback block
// no dependencies; imported by pcm_sample_playback_16ch

package pcmp_pkg;

    localparam int SAMPLE_ADDR_BITS = 16;
    localparam int CHANNELS         = 16;
    localparam int CH_SLOTS         = 16;
    localparam int RF_DEPTH         = 256;
    localparam int SMEM_DEPTH       = 1 << SAMPLE_ADDR_BITS;
    localparam int MIX_W            = 19;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_REG_WR  = 2'd0;
    localparam cmd_t CMD_REG_RD  = 2'd1;
    localparam cmd_t CMD_SMEM_WR = 2'd2;
    localparam cmd_t CMD_TICK    = 2'd3;

    // byte offsets inside a channel's eight-byte slot
    localparam logic [2:0] OFS_LVOL = 3'd2;
    localparam logic [2:0] OFS_RVOL = 3'd3;
    localparam logic [2:0] OFS_MID  = 3'd4;
    localparam logic [2:0] OFS_HIGH = 3'd5;
    localparam logic [2:0] OFS_END  = 3'd6;
    localparam logic [2:0] OFS_STEP = 3'd7;
    localparam logic [2:0] OFS_CTRL = 3'd6;

    localparam logic [7:0] SAMPLE_BIAS = 8'h80;
    localparam logic [7:0] CTRL_DISABLE = 8'h01;

    // value of a register byte that has not been written since reset
    function automatic logic [7:0] rf_reset_byte(input logic [7:0] a);
        logic [7:0] v;
        v = 8'h00;
        if (a[7] && (a[2:0] == OFS_CTRL) && (32'(a[6:3]) < CHANNELS))
        begin
            v = CTRL_DISABLE;
        end
        return v;
    endfunction

endpackage

// ----- rtl/pcm_sample_playback_16ch.sv -----
// pcm_sample_playback_16ch: sixteen-channel pcm sample player, top level
// depends on pcmp_pkg and pcmp_ram (register file and sample memory)

// One transaction in, one transaction out. Register write, register read and
// sample memory write load the result register from the done state, and the
// next transaction can be accepted once the block is back in idle. A render
// tick walks the channels one at a time through the register file's single
// read port: a disabled channel ends once its control byte is read, a channel
// that stops at its end page after the end test, and a playing channel after
// its right product; the result register is then loaded from the done state.
// One 9x8 multiplier is shared for the left and right products. The input is
// stalled while a transaction is in work; a finished result waits until the
// output register is free. Register file contents are tracked by per-byte valid
// bits, so no clearing pass follows reset; sample memory is not initialized.

module pcm_sample_playback_16ch
    import pcmp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [7:0]                  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  command,
    input  logic [15:0]                 address,
    input  logic [7:0]                  data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  read_data,
    output logic signed [MIX_W-1:0]     left_mix,
    output logic signed [MIX_W-1:0]     right_mix
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CH   = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [3:0] LAST_CH   = 4'(CHANNELS - 1);
    localparam logic [3:0] STEP_CTRL = 4'd1;
    localparam logic [3:0] STEP_TEST = 4'd9;
    localparam logic [3:0] STEP_LMUL = 4'd10;
    localparam logic [3:0] STEP_RMUL = 4'd11;

    logic [1:0]  state_reg;
    logic [3:0]  step_reg;
    logic [3:0]  ch_reg;
    cmd_t        cmd_reg;
    logic [7:0]  raddr_reg;

    logic [7:0]  bank_mask_reg;
    logic [4:0]  bank_shift_reg;

    logic [7:0]  ctrl_reg;
    logic [7:0]  pos_hi_reg;
    logic [7:0]  pos_mid_reg;
    logic [7:0]  end_reg;
    logic [7:0]  loop_hi_reg;
    logic [7:0]  loop_mid_reg;
    logic [7:0]  step_val_reg;
    logic [6:0]  lvol_reg;
    logic [6:0]  rvol_reg;
    logic [23:0] pos_reg;
    logic signed [8:0] samp_reg;
    logic signed [MIX_W-1:0] lmix_reg;
    logic signed [MIX_W-1:0] rmix_reg;
    logic [7:0]  frac_reg [CH_SLOTS];
    logic [RF_DEPTH-1:0] rf_valid_reg;
    logic [7:0]  rd_addr_reg;
    logic        rd_vld_reg;
    logic        out_valid_reg;

    logic        in_fire;
    logic        out_free;
    logic        rf_we;
    logic [7:0]  rf_waddr;
    logic [7:0]  rf_wdata;
    logic [7:0]  rf_raddr;
    logic [7:0]  rf_rdata;
    logic [7:0]  rf_q;
    logic        sm_we;
    logic [SAMPLE_ADDR_BITS-1:0] sm_waddr;
    logic [SAMPLE_ADDR_BITS-1:0] sm_raddr;
    logic [7:0]  sm_rdata;
    logic [31:0] addr32;
    logic [31:0] off32;
    logic [31:0] idx32;
    logic [7:0]  end_next;
    logic        at_end;
    logic        stop;
    logic [23:0] pos_sel;
    logic [23:0] pos_new;
    logic signed [8:0]  s_now;
    logic signed [8:0]  mul_a;
    logic [6:0]  mul_b;
    logic signed [16:0] prod;
    logic        last_ch;

    assign in_fire  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    assign rf_q = rd_vld_reg ? rf_rdata : rf_reset_byte(rd_addr_reg);

    assign addr32   = {16'h0000, address};
    assign sm_waddr = addr32[SAMPLE_ADDR_BITS-1:0];

    assign end_next = end_reg + 8'd1;
    assign at_end   = (pos_hi_reg == end_next);
    assign stop     = at_end && ctrl_reg[1];
    assign pos_sel  = at_end ? {loop_hi_reg, loop_mid_reg, 8'h00}
                             : {pos_hi_reg, pos_mid_reg, frac_reg[ch_reg]};
    assign off32    = {24'h000000, ctrl_reg & bank_mask_reg} << bank_shift_reg;
    assign idx32    = off32 + {16'h0000, pos_sel[23:8]};
    assign sm_raddr = idx32[SAMPLE_ADDR_BITS-1:0];
    assign pos_new  = pos_reg + {16'h0000, step_val_reg};

    // shared multiplier: left product first, right product next cycle
    assign s_now = $signed({1'b0, sm_rdata}) - $signed({1'b0, SAMPLE_BIAS});
    assign mul_a = (step_reg == STEP_LMUL) ? s_now : samp_reg;
    assign mul_b = (step_reg == STEP_LMUL) ? lvol_reg : rvol_reg;
    assign prod  = mul_a * $signed({1'b0, mul_b});

    assign last_ch = (ch_reg == LAST_CH);

    // register file and sample memory access per sequencer step
    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = address[7:0];
        rf_wdata = data;
        rf_raddr = raddr_reg;
        sm_we    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                rf_raddr = address[7:0];
                if (in_fire && (command == CMD_REG_WR))
                begin
                    rf_we = 1'b1;
                end
                if (in_fire && (command == CMD_SMEM_WR))
                begin
                    sm_we = 1'b1;
                end
            end
            S_CH:
            begin
                case (step_reg)
                    4'd0:    rf_raddr = {1'b1, ch_reg, OFS_CTRL};
                    4'd1:    rf_raddr = {1'b1, ch_reg, OFS_HIGH};
                    4'd2:    rf_raddr = {1'b1, ch_reg, OFS_MID};
                    4'd3:    rf_raddr = {1'b0, ch_reg, OFS_END};
                    4'd4:    rf_raddr = {1'b0, ch_reg, OFS_HIGH};
                    4'd5:    rf_raddr = {1'b0, ch_reg, OFS_MID};
                    4'd6:    rf_raddr = {1'b0, ch_reg, OFS_STEP};
                    4'd7:    rf_raddr = {1'b0, ch_reg, OFS_LVOL};
                    4'd8:    rf_raddr = {1'b0, ch_reg, OFS_RVOL};
                    STEP_TEST:
                    begin
                        rf_we    = stop;
                        rf_waddr = {1'b1, ch_reg, OFS_CTRL};
                        rf_wdata = ctrl_reg | CTRL_DISABLE;
                    end
                    STEP_LMUL:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = {1'b1, ch_reg, OFS_MID};
                        rf_wdata = pos_new[15:8];
                    end
                    STEP_RMUL:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = {1'b1, ch_reg, OFS_HIGH};
                        rf_wdata = pos_reg[23:16];
                    end
                    default: rf_raddr = raddr_reg;
                endcase
            end
            default: rf_raddr = raddr_reg;
        endcase
    end

    pcmp_ram #(
        .WIDTH(8),
        .DEPTH(RF_DEPTH)
    ) u_regfile (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    pcmp_ram #(
        .WIDTH(8),
        .DEPTH(SMEM_DEPTH)
    ) u_smem (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (data),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_mask_reg  <= 8'd112;
            bank_shift_reg <= 5'd12;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
            begin
                bank_mask_reg <= cfg_data;
            end
            else
            begin
                bank_shift_reg <= cfg_data[4:0];
            end
        end
    end

    // register file valid bits and read tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            rd_addr_reg  <= 8'h00;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            rd_addr_reg <= rf_raddr;
            rd_vld_reg  <= rf_valid_reg[rf_raddr];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 4'd0;
            ch_reg        <= 4'd0;
            cmd_reg       <= CMD_REG_WR;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CH_SLOTS; i++)
            begin
                frac_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        cmd_reg  <= command;
                        step_reg <= 4'd0;
                        ch_reg   <= 4'd0;
                        state_reg <= (command == CMD_TICK) ? S_CH : S_DONE;
                    end
                end
                S_CH:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (((step_reg == STEP_CTRL) && rf_q[0]) ||
                        ((step_reg == STEP_TEST) && stop) ||
                        (step_reg == STEP_RMUL))
                    begin
                        step_reg <= 4'd0;
                        ch_reg   <= ch_reg + 4'd1;
                        if (last_ch)
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    if (step_reg == STEP_RMUL)
                    begin
                        frac_reg[ch_reg] <= pos_reg[7:0];
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // channel datapath and output register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            raddr_reg <= address[7:0];
            lmix_reg  <= '0;
            rmix_reg  <= '0;
        end
        if (state_reg == S_CH)
        begin
            case (step_reg)
                4'd1: ctrl_reg     <= rf_q;
                4'd2: pos_hi_reg   <= rf_q;
                4'd3: pos_mid_reg  <= rf_q;
                4'd4: end_reg      <= rf_q;
                4'd5: loop_hi_reg  <= rf_q;
                4'd6: loop_mid_reg <= rf_q;
                4'd7: step_val_reg <= rf_q;
                4'd8: lvol_reg     <= rf_q[6:0];
                STEP_TEST:
                begin
                    rvol_reg <= rf_q[6:0];
                    pos_reg  <= pos_sel;
                end
                STEP_LMUL:
                begin
                    samp_reg <= s_now;
                    pos_reg  <= pos_new;
                    lmix_reg <= lmix_reg + MIX_W'(prod);
                end
                STEP_RMUL:
                begin
                    rmix_reg <= rmix_reg + MIX_W'(prod);
                end
                default: ctrl_reg <= ctrl_reg;
            endcase
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            read_data <= (cmd_reg == CMD_REG_RD) ? rf_q : 8'h00;
            left_mix  <= lmix_reg;
            right_mix <= rmix_reg;
        end
    end

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall)
        else $error("input not stalled after a transaction was accepted");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CH) |-> (step_reg <= STEP_RMUL))
        else $error("channel step counter out of range");

    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |=> rf_valid_reg[$past(rf_waddr)])
        else $error("register byte not marked valid after write");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result lost while output register was occupied");

endmodule

// ----- rtl/pcmp_ram.sv -----
// pcmp_ram: generic single-write, single-read memory with registered read data
// no dependencies

module pcmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
